/* rtl/ssas_pkg.sv */
// Shared types and constants for the spiral search align stepper.
// Depends on nothing; used by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package ssas_pkg;

   localparam int unsigned CSR_STEPS_PER_PIXEL = 0;
   localparam int unsigned CSR_SEARCH_STEP_X   = 1;
   localparam int unsigned CSR_SEARCH_STEP_Y   = 2;
   localparam int unsigned CSR_ALIGN_THRESHOLD = 3;
   localparam int unsigned CSR_CENTER_COLUMN   = 4;
   localparam int unsigned CSR_CENTER_ROW      = 5;

   localparam logic [23:0] STEPS_PER_PIXEL_RESET = 24'd65536;
   localparam logic [22:0] ALIGN_THRESHOLD_RESET = 23'd10;
   localparam logic signed [23:0] SMAX24 = 24'sh7FFFFF;
   localparam logic signed [23:0] SMIN24 = 24'sh800000;

   // Odd series coefficients of sin(pi/2 * x), Q30 magnitudes, highest first.
   localparam logic [31:0] QC1  = 32'd1686629713;
   localparam logic [31:0] QC3  = 32'd693598668;
   localparam logic [31:0] QC5  = 32'd85569306;
   localparam logic [31:0] QC7  = 32'd5026995;
   localparam logic [31:0] QC9  = 32'd172272;
   localparam logic [31:0] QC11 = 32'd3864;
   localparam logic [31:0] QC13 = 32'd61;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIG,
      ST_SCALE,
      ST_ROT,
      ST_SUM,
      ST_SEARCH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic trig;
      logic scale;
      logic rot;
      logic sum;
      logic search;
   } cmd_type;

   typedef struct packed {
      logic match_found;
      logic restart;
   } status_type;

   // sin(pi/2 * t / 16384) in Q1.15; evaluated only on constants
   function automatic logic [15:0] quarter_sine(input logic [14:0] t);
      logic [63:0] x2;
      logic [63:0] p;
      x2 = ({49'd0, t} * {49'd0, t}) << 2;
      p = {32'd0, QC13};
      p = {32'd0, QC11} - ((p * x2) >> 30);
      p = {32'd0, QC9} - ((p * x2) >> 30);
      p = {32'd0, QC7} - ((p * x2) >> 30);
      p = {32'd0, QC5} - ((p * x2) >> 30);
      p = {32'd0, QC3} - ((p * x2) >> 30);
      p = {32'd0, QC1} - ((p * x2) >> 30);
      p = (p * {49'd0, t} + 64'd268435456) >> 29;
      if (p > 64'd32768) begin
         p = 64'd32768;
      end
      return p[15:0];
   endfunction

   // Signed Q1.15 sine of a 16-bit angle, 17 bits wide.
   function automatic logic signed [16:0] table_sine(input logic [15:0] a);
      logic [15:0] s;
      s = a[14] ? quarter_sine(15'd16384 - {1'b0, a[13:0]})
                : quarter_sine({1'b0, a[13:0]});
      return a[15] ? -$signed({1'b0, s}) : $signed({1'b0, s});
   endfunction

endpackage
`default_nettype wire

/* rtl/ssas_ctrl.sv */
// Controller state machine for the spiral search align stepper.
// Depends on ssas_pkg; issues commands to ssas_datapath.
`timescale 1ns / 1ps
`default_nettype none
module ssas_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   input  wire ssas_pkg::status_type status,
   output ssas_pkg::cmd_type       cmd
);
   ssas_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssas_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ssas_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ssas_pkg::ST_TRIG;
            end
         end
         ssas_pkg::ST_TRIG: begin
            if (status.match_found) begin
               cmd.trig = 1'b1;
               state_in = ssas_pkg::ST_SCALE;
            end else begin
               cmd.search = 1'b1;
               state_in = ssas_pkg::ST_OUT;
            end
         end
         ssas_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ssas_pkg::ST_ROT;
         end
         ssas_pkg::ST_ROT: begin
            cmd.rot  = 1'b1;
            state_in = ssas_pkg::ST_SUM;
         end
         ssas_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ssas_pkg::ST_OUT;
         end
         ssas_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ssas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssas_pkg::ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ssas_pkg::ST_TRIG)
      else $error("load did not start work");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("new word taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      cmd.sum |=> rsp_valid)
      else $error("result not shown after sum");
endmodule
`default_nettype wire

/* rtl/ssas_datapath.sv */
// Datapath for the spiral search align stepper: registers, spiral state,
// sine table, multipliers and result. Depends on ssas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssas_datapath #(
   parameter int NUM_PAIRS       = 21,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ssas_pkg::cmd_type  cmd,
   output ssas_pkg::status_type    status,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_data,
   input  wire logic               req_restart,
   input  wire logic               req_match_found,
   input  wire logic [15:0]        req_match_row,
   input  wire logic [15:0]        req_match_column,
   input  wire logic [15:0]        req_match_angle,
   output logic signed [23:0]      rsp_move_x,
   output logic signed [23:0]      rsp_move_y,
   output logic                    rsp_aligned,
   output logic                    rsp_from_search,
   output logic                    rsp_exhausted
);
   localparam int TABLE_DEPTH = 1 << TRIG_TABLE_BITS;
   localparam int SHIFT       = 16 - TRIG_TABLE_BITS;

   // Sine table of Q1.15 values, one per quantized angle.
   function automatic logic signed [16:0] sine_at(input int i);
      logic [15:0] a;
      a = 16'(i << SHIFT);
      return ssas_pkg::table_sine(a);
   endfunction

   logic signed [16:0] sine_rom [TABLE_DEPTH];
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
      assign sine_rom[g] = sine_at(g);
   end

   // configuration
   logic [23:0]        spp_ff;
   logic signed [23:0] ssx_ff, ssy_ff;
   logic [22:0]        thr_ff;
   logic [15:0]        ccol_ff, crow_ff;

   // spiral state
   logic [15:0]        fib_ff, leg_ff, done_ff;
   logic               second_ff;
   logic [4:0]         pair_ff;
   logic signed [23:0] dirx_ff, diry_ff;

   // item registers
   logic               restart_ff, found_ff;
   logic signed [16:0] ex_ff, ey_ff;
   logic [TRIG_TABLE_BITS-1:0] aidx_ff;
   logic signed [16:0] sin_ff, cos_ff;
   logic signed [41:0] dx_ff, dy_ff;
   logic signed [59:0] cdx_ff, sdy_ff, sdx_ff, cdy_ff;
   logic signed [23:0] mvx_ff, mvy_ff;
   logic               aligned_ff, search_ff, exh_ff;

   logic at_start;
   assign at_start = (pair_ff == '0) && !second_ff && (done_ff == '0);
   assign status.match_found = found_ff;
   assign status.restart     = restart_ff;

   function automatic logic signed [23:0] to_steps(input logic signed [60:0] v);
      logic [60:0] m;
      logic [25:0] q;
      m = v[60] ? 61'(-v) : 61'(v);
      q = m[60:35];
      if (v[60]) begin
         return (q >= 26'd8388608) ? ssas_pkg::SMIN24 : -$signed({1'b0, q[22:0]});
      end
      return (q > 26'd8388607) ? ssas_pkg::SMAX24 : $signed({1'b0, q[22:0]});
   endfunction

   logic signed [60:0] mx, my;
   logic [60:0]        amx, amy, thr_w;
   assign mx    = 61'(cdx_ff) - 61'(sdy_ff);
   assign my    = 61'(sdx_ff) + 61'(cdy_ff);
   assign amx   = mx[60] ? 61'(-mx) : 61'(mx);
   assign amy   = my[60] ? 61'(-my) : 61'(my);
   assign thr_w = {3'd0, thr_ff, 35'd0};

   logic [15:0] done_next;
   logic [16:0] fib_sum;
   assign done_next = done_ff + 16'd1;
   assign fib_sum   = {1'b0, fib_ff} + {1'b0, leg_ff};

   logic [TRIG_TABLE_BITS-1:0] cidx;
   assign cidx = aidx_ff + TRIG_TABLE_BITS'(TABLE_DEPTH / 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff    <= ssas_pkg::STEPS_PER_PIXEL_RESET;
         ssx_ff    <= '0;
         ssy_ff    <= '0;
         thr_ff    <= ssas_pkg::ALIGN_THRESHOLD_RESET;
         ccol_ff   <= '0;
         crow_ff   <= '0;
         fib_ff    <= 16'd1;
         leg_ff    <= 16'd1;
         done_ff   <= '0;
         second_ff <= 1'b0;
         pair_ff   <= '0;
         dirx_ff   <= '0;
         diry_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               3'(ssas_pkg::CSR_STEPS_PER_PIXEL): spp_ff <= csr_data;
               3'(ssas_pkg::CSR_SEARCH_STEP_X): begin
                  ssx_ff <= csr_data;
                  if (at_start) dirx_ff <= csr_data;
               end
               3'(ssas_pkg::CSR_SEARCH_STEP_Y): begin
                  ssy_ff <= csr_data;
                  if (at_start) diry_ff <= csr_data;
               end
               3'(ssas_pkg::CSR_ALIGN_THRESHOLD): thr_ff <= csr_data[22:0];
               3'(ssas_pkg::CSR_CENTER_COLUMN): ccol_ff <= csr_data[15:0];
               3'(ssas_pkg::CSR_CENTER_ROW): crow_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         if (cmd.load && req_restart) begin
            fib_ff    <= 16'd1;
            leg_ff    <= 16'd1;
            done_ff   <= '0;
            second_ff <= 1'b0;
            pair_ff   <= '0;
            dirx_ff   <= ssx_ff;
            diry_ff   <= ssy_ff;
         end
         if (cmd.search && (32'(pair_ff) < NUM_PAIRS)) begin
            if (done_next >= leg_ff) begin
               dirx_ff <= (diry_ff == ssas_pkg::SMIN24) ? ssas_pkg::SMAX24 : -diry_ff;
               diry_ff <= dirx_ff;
               done_ff <= '0;
               if (second_ff) begin
                  second_ff <= 1'b0;
                  pair_ff   <= pair_ff + 5'd1;
                  fib_ff    <= leg_ff;
                  leg_ff    <= fib_sum[16] ? 16'hFFFF : fib_sum[15:0];
               end else begin
                  second_ff <= 1'b1;
               end
            end else begin
               done_ff <= done_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         restart_ff <= req_restart;
         found_ff   <= req_match_found;
         ex_ff      <= $signed({1'b0, req_match_column}) - $signed({1'b0, ccol_ff});
         ey_ff      <= $signed({1'b0, req_match_row}) - $signed({1'b0, crow_ff});
         aidx_ff    <= req_match_angle[15:SHIFT];
      end
      if (cmd.trig) begin
         sin_ff <= sine_rom[aidx_ff];
         cos_ff <= sine_rom[cidx];
      end
      if (cmd.scale) begin
         dx_ff <= 42'(ex_ff) * 42'($signed({1'b0, spp_ff}));
         dy_ff <= 42'(ey_ff) * 42'($signed({1'b0, spp_ff}));
      end
      if (cmd.rot) begin
         cdx_ff <= 60'(cos_ff) * 60'(dx_ff);
         sdy_ff <= 60'(sin_ff) * 60'(dy_ff);
         sdx_ff <= 60'(sin_ff) * 60'(dx_ff);
         cdy_ff <= 60'(cos_ff) * 60'(dy_ff);
      end
      if (cmd.sum) begin
         mvx_ff     <= to_steps(mx);
         mvy_ff     <= to_steps(my);
         aligned_ff <= (amx < thr_w) && (amy < thr_w);
         search_ff  <= 1'b0;
         exh_ff     <= 1'b0;
      end
      if (cmd.search) begin
         aligned_ff <= 1'b0;
         search_ff  <= 1'b1;
         if (32'(pair_ff) >= NUM_PAIRS) begin
            exh_ff <= 1'b1;
            mvx_ff <= '0;
            mvy_ff <= '0;
         end else begin
            exh_ff <= 1'b0;
            mvx_ff <= dirx_ff;
            mvy_ff <= diry_ff;
         end
      end
   end

   assign rsp_move_x      = mvx_ff;
   assign rsp_move_y      = mvy_ff;
   assign rsp_aligned     = aligned_ff;
   assign rsp_from_search = search_ff;
   assign rsp_exhausted   = exh_ff;

   assert property (@(posedge clock) disable iff (reset)
      32'(pair_ff) <= NUM_PAIRS)
      else $error("pair index past the end");
   assert property (@(posedge clock) disable iff (reset)
      cmd.sum |=> !search_ff && !exh_ff)
      else $error("correction flagged as search");
   assert property (@(posedge clock) disable iff (reset)
      cmd.search && (32'(pair_ff) >= NUM_PAIRS) |=> $stable(pair_ff))
      else $error("exhausted spiral moved");
endmodule
`default_nettype wire

/* rtl/spiral_search_align_stepper.sv */
// Top level of the spiral search align stepper.
// Depends on ssas_pkg, ssas_ctrl and ssas_datapath.
`timescale 1ns / 1ps
`default_nettype none
// One match report word goes in, one move word comes out. A report with a
// match goes through the sine and cosine table read, the pixel to step
// scaling multiply, the rotation multiplies and the sum and saturate step,
// then its result word is shown in the result state; a report without a
// match goes through a spiral step, then the result state. The chain of
// dependent multiplies in the datapath sets these steps. The block holds
// one report at a time: req_stall stays high after acceptance until the
// result word is taken, so the next word is not accepted before that.
// Configuration writes are always ready and are meant to be issued only
// while the block is idle.
module spiral_search_align_stepper #(
   parameter int NUM_PAIRS       = 21,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_restart,
   input  wire logic               req_match_found,
   input  wire logic [15:0]        req_match_row,
   input  wire logic [15:0]        req_match_column,
   input  wire logic [15:0]        req_match_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_move_x,
   output logic signed [23:0]      rsp_move_y,
   output logic                    rsp_aligned,
   output logic                    rsp_from_search,
   output logic                    rsp_exhausted,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_data
);
   ssas_pkg::cmd_type    cmd;
   ssas_pkg::status_type status;

   // Configuration is accepted in every cycle.
   assign csr_ready = 1'b1;

   ssas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   ssas_datapath #(
      .NUM_PAIRS       (NUM_PAIRS),
      .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_restart      (req_restart),
      .req_match_found  (req_match_found),
      .req_match_row    (req_match_row),
      .req_match_column (req_match_column),
      .req_match_angle  (req_match_angle),
      .rsp_move_x       (rsp_move_x),
      .rsp_move_y       (rsp_move_y),
      .rsp_aligned      (rsp_aligned),
      .rsp_from_search  (rsp_from_search),
      .rsp_exhausted    (rsp_exhausted)
   );
endmodule
`default_nettype wire
